FILE: sv/dipsm_pkg.sv
// Package for the display idle power manager.
// Holds event codes, level codes, register indexes and field widths.
// No dependencies.
package dipsm_pkg;

  localparam int OP_W   = 3;
  localparam int TIME_W = 32;
  localparam int DLY_W  = 31;
  localparam int PCT_W  = 7;
  localparam int LVL_W  = 2;
  localparam int IDX_W  = 3;

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_WAKE      = 3'd1;
  localparam logic [OP_W-1:0] OP_FORCE_OFF = 3'd2;
  localparam logic [OP_W-1:0] OP_PRESS     = 3'd3;
  localparam logic [OP_W-1:0] OP_TOUCH     = 3'd4;

  localparam logic [LVL_W-1:0] LVL_ACTIVE = 2'd0;
  localparam logic [LVL_W-1:0] LVL_DIM    = 2'd1;
  localparam logic [LVL_W-1:0] LVL_OFF    = 2'd2;
  localparam logic [LVL_W-1:0] LVL_SLEEP  = 2'd3;

  localparam logic [IDX_W-1:0] REG_DIM_AFTER  = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFF_AFTER  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SLEEP_XTRA = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIM_PCT    = 3'd3;
  localparam logic [IDX_W-1:0] REG_USER_PCT   = 3'd4;

  localparam logic [DLY_W-1:0] DIM_AFTER_RST  = 31'd30000;
  localparam logic [DLY_W-1:0] OFF_AFTER_RST  = 31'd60000;
  localparam logic [DLY_W-1:0] SLEEP_XTRA_RST = 31'd300000;
  localparam logic [PCT_W-1:0] DIM_PCT_RST    = 7'd10;
  localparam logic [PCT_W-1:0] USER_PCT_RST   = 7'd100;

endpackage

FILE: sv/dipsm_if.sv
// Channel interfaces of the display idle power manager: events, results and
// configuration writes. Depends on dipsm_pkg.
interface dipsm_evt_if;
  logic                          valid;
  logic                          ready;
  logic [dipsm_pkg::OP_W-1:0]    op;
  logic [dipsm_pkg::TIME_W-1:0]  now_ms;
  logic                          awake_req;
  logic                          sleep_block;
  logic                          pressed;
  modport source (output valid, op, now_ms, awake_req, sleep_block, pressed,
                  input ready);
  modport sink (input valid, op, now_ms, awake_req, sleep_block, pressed,
                output ready);
endinterface

interface dipsm_res_if;
  logic                          valid;
  logic                          ready;
  logic [dipsm_pkg::LVL_W-1:0]   level;
  logic [dipsm_pkg::PCT_W-1:0]   brightness_pct;
  logic                          press_delivered;
  modport source (output valid, level, brightness_pct, press_delivered, input ready);
  modport sink (input valid, level, brightness_pct, press_delivered, output ready);
endinterface

interface dipsm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dipsm_pkg::IDX_W-1:0]   index;
  logic [dipsm_pkg::DLY_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/display_idle_power_state_machine.sv
// Top level of the display idle power manager.
// Depends on dipsm_pkg and the channel interfaces in dipsm_if.sv.
//
// The block accepts one event per clock cycle while its result is not stalled
// and returns one result per event: the event is captured in an input
// register, the next level, idle reference and touch latch are worked out in
// one pass of logic (three 32-bit adds and the deadline compares), and the
// result lands in an output register. A stalled result only holds the input
// register once it is full.
// Configuration writes are always taken at once.
module display_idle_power_state_machine (
  input logic          clk,
  input logic          rst,
  dipsm_cfg_if.sink    cfg,
  dipsm_evt_if.sink    evt,
  dipsm_res_if.source  res
);

  logic [dipsm_pkg::DLY_W-1:0]  dim_after_ms;
  logic [dipsm_pkg::DLY_W-1:0]  off_after_ms;
  logic [dipsm_pkg::DLY_W-1:0]  sleep_extra_ms;
  logic [dipsm_pkg::PCT_W-1:0]  dim_brightness_pct;
  logic [dipsm_pkg::PCT_W-1:0]  user_brightness_pct;

  logic [dipsm_pkg::LVL_W-1:0]  power_level;
  logic [dipsm_pkg::LVL_W-1:0]  power_level_next;
  logic [dipsm_pkg::TIME_W-1:0] idle_reference;
  logic [dipsm_pkg::TIME_W-1:0] idle_reference_next;
  logic                         touch_was_down;
  logic                         touch_was_down_next;
  logic                         touch_swallowing;
  logic                         touch_swallowing_next;

  logic                         s1_valid;
  logic [dipsm_pkg::OP_W-1:0]   s1_op;
  logic [dipsm_pkg::TIME_W-1:0] s1_now;
  logic                         s1_awake_req;
  logic                         s1_sleep_block;
  logic                         s1_pressed;

  logic                         proc;
  logic                         delivered;
  logic [dipsm_pkg::PCT_W-1:0]  bright;
  logic [dipsm_pkg::TIME_W-1:0] off_dl;
  logic [dipsm_pkg::TIME_W-1:0] sleep_dl;
  logic [dipsm_pkg::TIME_W-1:0] dim_dl;
  logic [dipsm_pkg::TIME_W-1:0] off_diff;
  logic [dipsm_pkg::TIME_W-1:0] sleep_diff;
  logic [dipsm_pkg::TIME_W-1:0] dim_diff;
  logic                         off_met;
  logic                         sleep_met;
  logic                         dim_met;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_after_ms        <= dipsm_pkg::DIM_AFTER_RST;
      off_after_ms        <= dipsm_pkg::OFF_AFTER_RST;
      sleep_extra_ms      <= dipsm_pkg::SLEEP_XTRA_RST;
      dim_brightness_pct  <= dipsm_pkg::DIM_PCT_RST;
      user_brightness_pct <= dipsm_pkg::USER_PCT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        dipsm_pkg::REG_DIM_AFTER:  dim_after_ms <= cfg.data;
        dipsm_pkg::REG_OFF_AFTER:  off_after_ms <= cfg.data;
        dipsm_pkg::REG_SLEEP_XTRA: sleep_extra_ms <= cfg.data;
        dipsm_pkg::REG_DIM_PCT:    dim_brightness_pct <= cfg.data[dipsm_pkg::PCT_W-1:0];
        dipsm_pkg::REG_USER_PCT:   user_brightness_pct <= cfg.data[dipsm_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  assign proc      = s1_valid && (!res.valid || res.ready);
  assign evt.ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      s1_op          <= evt.op;
      s1_now         <= evt.now_ms;
      s1_awake_req   <= evt.awake_req;
      s1_sleep_block <= evt.sleep_block;
      s1_pressed     <= evt.pressed;
    end
  end

  // A deadline counts as reached when now minus the deadline is not negative
  // in 32-bit wraparound arithmetic.
  assign off_dl     = idle_reference + {1'b0, off_after_ms};
  assign sleep_dl   = off_dl + {1'b0, sleep_extra_ms};
  assign dim_dl     = idle_reference + {1'b0, dim_after_ms};
  assign off_diff   = s1_now - off_dl;
  assign sleep_diff = s1_now - sleep_dl;
  assign dim_diff   = s1_now - dim_dl;
  assign off_met    = !off_diff[dipsm_pkg::TIME_W-1];
  assign sleep_met  = !sleep_diff[dipsm_pkg::TIME_W-1];
  assign dim_met    = !dim_diff[dipsm_pkg::TIME_W-1];

  always_comb begin
    power_level_next      = power_level;
    idle_reference_next   = idle_reference;
    touch_was_down_next   = touch_was_down;
    touch_swallowing_next = touch_swallowing;
    delivered             = 1'b0;
    case (s1_op)
      dipsm_pkg::OP_TICK: begin
        if (s1_awake_req) begin
          power_level_next    = dipsm_pkg::LVL_ACTIVE;
          idle_reference_next = s1_now;
        end else if (power_level != dipsm_pkg::LVL_SLEEP) begin
          if (!s1_sleep_block && sleep_met) begin
            power_level_next = dipsm_pkg::LVL_SLEEP;
          end else if (power_level != dipsm_pkg::LVL_OFF) begin
            if (off_met) begin
              power_level_next = dipsm_pkg::LVL_OFF;
            end else if (dim_met) begin
              power_level_next = dipsm_pkg::LVL_DIM;
            end
          end
        end
      end
      dipsm_pkg::OP_WAKE: begin
        power_level_next    = dipsm_pkg::LVL_ACTIVE;
        idle_reference_next = s1_now;
      end
      dipsm_pkg::OP_FORCE_OFF: begin
        power_level_next = dipsm_pkg::LVL_OFF;
      end
      dipsm_pkg::OP_PRESS: begin
        if (!s1_awake_req) begin
          if (power_level == dipsm_pkg::LVL_ACTIVE) begin
            power_level_next = dipsm_pkg::LVL_OFF;
          end else begin
            power_level_next    = dipsm_pkg::LVL_ACTIVE;
            idle_reference_next = s1_now;
          end
        end
      end
      dipsm_pkg::OP_TOUCH: begin
        if (!s1_pressed) begin
          touch_was_down_next   = 1'b0;
          touch_swallowing_next = 1'b0;
        end else begin
          if (!touch_was_down) begin
            touch_was_down_next   = 1'b1;
            touch_swallowing_next = (power_level != dipsm_pkg::LVL_ACTIVE);
            if (power_level != dipsm_pkg::LVL_ACTIVE) begin
              power_level_next    = dipsm_pkg::LVL_ACTIVE;
              idle_reference_next = s1_now;
            end
          end
          delivered = !touch_swallowing_next;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (power_level_next)
      dipsm_pkg::LVL_ACTIVE: bright = user_brightness_pct;
      dipsm_pkg::LVL_DIM:    bright = dim_brightness_pct;
      default:               bright = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_level      <= dipsm_pkg::LVL_ACTIVE;
      idle_reference   <= '0;
      touch_was_down   <= 1'b0;
      touch_swallowing <= 1'b0;
    end else if (proc) begin
      power_level      <= power_level_next;
      idle_reference   <= idle_reference_next;
      touch_was_down   <= touch_was_down_next;
      touch_swallowing <= touch_swallowing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (proc) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res.level           <= power_level_next;
      res.brightness_pct  <= bright;
      res.press_delivered <= delivered;
    end
  end

`ifndef NO_ASSERTIONS
  a_level_tracks_state: assert property (@(posedge clk) disable iff (rst)
    proc |=> res.level == power_level)
    else $error("result level differs from the kept power level");

  a_dark_levels_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.level == dipsm_pkg::LVL_OFF || res.level == dipsm_pkg::LVL_SLEEP)
      |-> res.brightness_pct == '0)
    else $error("nonzero brightness reported while off or asleep");

  a_swallow_needs_down: assert property (@(posedge clk) disable iff (rst)
    touch_swallowing |-> touch_was_down)
    else $error("touch swallow latch set without a press in progress");
`endif

endmodule
